>>> design/touch_swipe_gesture_classifier_macros.svh
// ----------------------------------------------------------------------------
// Touch swipe gesture classifier: assertion macros
// Clocked, reset-gated property checks used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef TOUCH_SWIPE_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCH_SWIPE_GESTURE_CLASSIFIER_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define TSG_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define TSG_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tsg_pkg.sv
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types, event codes, register indexes and scaling constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tsg_pkg;

  localparam int COORD_W    = 12;
  localparam int EV_TYPE_W  = 5;
  localparam int EV_CODE_W  = 10;
  localparam int EV_VALUE_W = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int RAW_BITS_DEF = 12;

  // Event decode
  localparam logic [EV_TYPE_W-1:0] EVT_KEY   = 5'd1;
  localparam logic [EV_TYPE_W-1:0] EVT_ABS   = 5'd3;
  localparam logic [EV_CODE_W-1:0] AXIS_X    = 10'd0;
  localparam logic [EV_CODE_W-1:0] AXIS_Y    = 10'd1;
  localparam logic [EV_CODE_W-1:0] KEY_TOUCH = 10'd330;

  // x * 800 / 1024: multiply, then shift
  localparam logic [9:0] X_SCALE_NUM   = 10'd800;
  localparam int         X_SCALE_SHIFT = 10;
  // y * 480 / 600 == (y * 4) / 5; divide by 5 through reciprocal 52429 / 2^18,
  // exact for dividends below 2^16
  localparam int          Y_PRE_SHIFT   = 2;
  localparam logic [15:0] Y_RECIP       = 16'd52429;
  localparam int          Y_RECIP_SHIFT = 18;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_LEFT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_RIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_BOTTOM     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_BOTTOM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_THRESHOLD = 3'd4;

  localparam logic [COORD_W-1:0] RST_BUTTON_LEFT     = 12'd700;
  localparam logic [COORD_W-1:0] RST_BUTTON_RIGHT    = 12'd800;
  localparam logic [COORD_W-1:0] RST_EXIT_BOTTOM     = 12'd100;
  localparam logic [COORD_W-1:0] RST_AUTO_BOTTOM     = 12'd200;
  localparam logic [COORD_W-1:0] RST_SWIPE_THRESHOLD = 12'd20;

  typedef enum logic [2:0] {
    GST_EXIT  = 3'd0,
    GST_AUTO  = 3'd1,
    GST_RIGHT = 3'd2,
    GST_LEFT  = 3'd3,
    GST_DOWN  = 3'd4,
    GST_UP    = 3'd5,
    GST_OTHER = 3'd6
  } gesture_t;

  typedef struct packed {
    logic [COORD_W-1:0] button_left;
    logic [COORD_W-1:0] button_right;
    logic [COORD_W-1:0] exit_bottom;
    logic [COORD_W-1:0] auto_bottom;
    logic [COORD_W-1:0] swipe_threshold;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] last_x;
    logic [COORD_W-1:0] last_y;
    logic               seen_x;
    logic               seen_y;
  } touch_t;

endpackage

`default_nettype wire

>>> design/tsg_scale.sv
// ----------------------------------------------------------------------------
// tsg_scale
// Masks the raw axis value and scales it to screen x and y coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_scale
  import tsg_pkg::*;
#(
  parameter int RAW_BITS = RAW_BITS_DEF
) (
  input  wire logic [EV_VALUE_W-1:0] ev_value,
  output logic      [COORD_W-1:0]    scaled_x,
  output logic      [COORD_W-1:0]    scaled_y,
  output logic                       raw_zero
);

  localparam logic [EV_VALUE_W-1:0] RAW_MASK =
    (RAW_BITS >= EV_VALUE_W) ? {EV_VALUE_W{1'b1}}
                             : EV_VALUE_W'((1 << RAW_BITS) - 1);
  localparam int XP_W = EV_VALUE_W + 10;
  localparam int YN_W = EV_VALUE_W + Y_PRE_SHIFT;
  localparam int YP_W = YN_W + 16;

  logic [EV_VALUE_W-1:0] raw;
  logic [XP_W-1:0]       x_prod;
  logic [YN_W-1:0]       y_num;
  logic [YP_W-1:0]       y_prod;

  assign raw      = ev_value & RAW_MASK;
  assign raw_zero = (raw == '0);

  // Results stay within 12 bits for a 12-bit raw value, so no clamp is needed
  assign x_prod   = XP_W'(raw) * XP_W'(X_SCALE_NUM);
  assign scaled_x = x_prod[X_SCALE_SHIFT +: COORD_W];

  assign y_num    = {raw, {Y_PRE_SHIFT{1'b0}}};
  assign y_prod   = YP_W'(y_num) * YP_W'(Y_RECIP);
  assign scaled_y = y_prod[Y_RECIP_SHIFT +: COORD_W];

endmodule

`default_nettype wire

>>> design/tsg_classify.sv
// ----------------------------------------------------------------------------
// tsg_classify
// Turns the latched touch start and end points into a gesture code.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_classify
  import tsg_pkg::*;
(
  input  wire touch_t   touch,
  input  wire cfg_t     cfg,
  output gesture_t      gesture
);

  logic               still;
  logic               in_col;
  logic               exit_hit;
  logic               auto_hit;
  logic signed [13:0] dx;
  logic signed [13:0] dy;
  logic signed [13:0] thr;
  logic        [13:0] ax;
  logic        [13:0] ay;

  assign still  = (touch.first_x == touch.last_x) && (touch.first_y == touch.last_y);
  assign in_col = (touch.first_x > cfg.button_left) && (touch.first_x < cfg.button_right);
  assign exit_hit = still && in_col && (touch.first_y != '0) &&
                    (touch.first_y < cfg.exit_bottom);
  assign auto_hit = still && in_col && (touch.first_y > cfg.exit_bottom) &&
                    (touch.first_y < cfg.auto_bottom);

  assign dx  = $signed({2'b00, touch.last_x}) - $signed({2'b00, touch.first_x});
  assign dy  = $signed({2'b00, touch.last_y}) - $signed({2'b00, touch.first_y});
  assign thr = $signed({2'b00, cfg.swipe_threshold});
  assign ax  = dx[13] ? 14'(-dx) : 14'(dx);
  assign ay  = dy[13] ? 14'(-dy) : 14'(dy);

  always_comb begin
    gesture = GST_OTHER;
    if (touch.seen_x && touch.seen_y) begin
      if (exit_hit) begin
        gesture = GST_EXIT;
      end else if (auto_hit) begin
        gesture = GST_AUTO;
      end else if (ax > ay) begin
        if (dx > thr) begin
          gesture = GST_RIGHT;
        end else if (dx < -thr) begin
          gesture = GST_LEFT;
        end
      end else if (ay > ax) begin
        if (dy > thr) begin
          gesture = GST_DOWN;
        end else if (dy < -thr) begin
          gesture = GST_UP;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> design/touch_swipe_gesture_classifier.sv
// ----------------------------------------------------------------------------
// touch_swipe_gesture_classifier
// Tracks one touch from raw events and reports a gesture on release.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | ev_type, ev_code, ev_value
//  out_    | output    | out_valid/out_stall | gesture, start/end x and y
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  An item is held in the input register and is applied to the touch state
//  as it leaves it; a release lands in the result register at that same
//  edge, so out_valid is set as the release leaves the input register.
//  One item per cycle sustained; the input stalls only while a release waits
//  in the input register behind a stalled, full result register.
//  Reset clears the touch state and loads the register defaults; cfg_ready is
//  always high.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_swipe_gesture_classifier
  import tsg_pkg::*;
#(
  parameter int RAW_BITS = RAW_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [EV_TYPE_W-1:0]  in_ev_type,
  input  wire logic [EV_CODE_W-1:0]  in_ev_code,
  input  wire logic [EV_VALUE_W-1:0] in_ev_value,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [2:0]                 out_gesture,
  output logic [COORD_W-1:0]         out_start_x,
  output logic [COORD_W-1:0]         out_start_y,
  output logic [COORD_W-1:0]         out_end_x,
  output logic [COORD_W-1:0]         out_end_y,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COORD_W-1:0]    cfg_data
);

  // Input register
  logic                  s1_valid_r, s1_valid_nxt;
  logic [EV_TYPE_W-1:0]  s1_type_r;
  logic [EV_CODE_W-1:0]  s1_code_r;
  logic [EV_VALUE_W-1:0] s1_value_r;

  cfg_t     cfg_r, cfg_nxt;
  touch_t   touch_r, touch_nxt;

  logic                  out_valid_r, out_valid_nxt;
  gesture_t              out_gesture_r;
  touch_t                out_touch_r;

  logic [COORD_W-1:0]    scaled_x;
  logic [COORD_W-1:0]    scaled_y;
  logic                  raw_zero;
  gesture_t              gesture;

  logic in_accept;
  logic is_x;
  logic is_y;
  logic is_rel;
  logic out_free;
  logic s1_go;

  tsg_scale #(
    .RAW_BITS (RAW_BITS)
  ) u_scale (
    .ev_value (s1_value_r),
    .scaled_x (scaled_x),
    .scaled_y (scaled_y),
    .raw_zero (raw_zero)
  );

  tsg_classify u_classify (
    .touch   (touch_r),
    .cfg     (cfg_r),
    .gesture (gesture)
  );

  assign is_x   = (s1_type_r == EVT_ABS) && (s1_code_r == AXIS_X);
  assign is_y   = (s1_type_r == EVT_ABS) && (s1_code_r == AXIS_Y);
  assign is_rel = (s1_type_r == EVT_KEY) && (s1_code_r == KEY_TOUCH) && raw_zero;

  assign out_free  = !out_valid_r || !out_stall;
  // Only a release needs room in the result register
  assign s1_go     = s1_valid_r && (!is_rel || out_free);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    touch_nxt = touch_r;
    if (s1_go) begin
      if (is_x) begin
        if (!touch_r.seen_x) begin
          touch_nxt.first_x = scaled_x;
        end
        touch_nxt.last_x = scaled_x;
        touch_nxt.seen_x = 1'b1;
      end else if (is_y) begin
        if (!touch_r.seen_y) begin
          touch_nxt.first_y = scaled_y;
        end
        touch_nxt.last_y = scaled_y;
        touch_nxt.seen_y = 1'b1;
      end else if (is_rel) begin
        touch_nxt = '0;
      end
    end
  end

  always_comb begin
    if (s1_go && is_rel) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BUTTON_LEFT:     cfg_nxt.button_left     = cfg_data;
        CFG_BUTTON_RIGHT:    cfg_nxt.button_right    = cfg_data;
        CFG_EXIT_BOTTOM:     cfg_nxt.exit_bottom     = cfg_data;
        CFG_AUTO_BOTTOM:     cfg_nxt.auto_bottom     = cfg_data;
        CFG_SWIPE_THRESHOLD: cfg_nxt.swipe_threshold = cfg_data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      touch_r     <= '0;
      cfg_r.button_left     <= RST_BUTTON_LEFT;
      cfg_r.button_right    <= RST_BUTTON_RIGHT;
      cfg_r.exit_bottom     <= RST_EXIT_BOTTOM;
      cfg_r.auto_bottom     <= RST_AUTO_BOTTOM;
      cfg_r.swipe_threshold <= RST_SWIPE_THRESHOLD;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      touch_r     <= touch_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_type_r  <= in_ev_type;
      s1_code_r  <= in_ev_code;
      s1_value_r <= in_ev_value;
    end
    if (s1_go && is_rel) begin
      out_gesture_r <= gesture;
      out_touch_r   <= touch_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_gesture = out_gesture_r;
  assign out_start_x = out_touch_r.first_x;
  assign out_start_y = out_touch_r.first_y;
  assign out_end_x   = out_touch_r.last_x;
  assign out_end_y   = out_touch_r.last_y;

`include "touch_swipe_gesture_classifier_macros.svh"

  `TSG_ASSERT_NXT(a_release_clears, clk, rst_n, s1_go && is_rel,
    out_valid_r && !touch_r.seen_x && !touch_r.seen_y, "release did not clear touch")
  `TSG_ASSERT_IMP(a_tap_still, clk, rst_n,
    out_valid_r && (out_gesture_r == GST_EXIT || out_gesture_r == GST_AUTO),
    out_touch_r.first_x == out_touch_r.last_x && out_touch_r.first_y == out_touch_r.last_y,
    "tap reported for a moving touch")
  `TSG_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall,
    s1_valid_r && is_rel && out_valid_r && out_stall, "input stalled without a blocked release")
  `TSG_ASSERT_IMP(a_unseen_x_zero, clk, rst_n, !touch_r.seen_x,
    touch_r.first_x == '0 && touch_r.last_x == '0, "x point set without an x event")

endmodule

`default_nettype wire
